/* rtl/core/pra_pkg.sv */
// ----------------------------------------------------------------------------
// pra_pkg
// shared types, constants and helpers of the axis-angle point rotation unit
// ----------------------------------------------------------------------------
package pra_pkg;

    // default and table sizes of the cordic
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN          = 24;
    localparam int ATAN_IDX_W        = 5;

    // stream widths
    localparam int S_TDATA_W = 256;
    localparam int M_TDATA_W = 104;

    // cordic start value: gain 0.60725293500888 in q2.30
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [39:0] ONE_Q30         = 40'sd1073741824;

    // quadrant codes after angle reduction
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // side data that travels with an item through the cordic and matrix stages
    typedef struct packed {
        logic signed [31:0] pivot_x;
        logic signed [31:0] pivot_y;
        logic signed [31:0] pivot_z;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [33:0] dz;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic [1:0]         quad;
    } side_t;

    // arctangent table, 2^32 per turn
    function automatic logic signed [31:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [31:0] v;
        begin
            unique case (idx)
                5'd0:  v = 32'sd536870912;
                5'd1:  v = 32'sd316933406;
                5'd2:  v = 32'sd167458907;
                5'd3:  v = 32'sd85004756;
                5'd4:  v = 32'sd42667331;
                5'd5:  v = 32'sd21354465;
                5'd6:  v = 32'sd10679838;
                5'd7:  v = 32'sd5340245;
                5'd8:  v = 32'sd2670163;
                5'd9:  v = 32'sd1335087;
                5'd10: v = 32'sd667544;
                5'd11: v = 32'sd333772;
                5'd12: v = 32'sd166886;
                5'd13: v = 32'sd83443;
                5'd14: v = 32'sd41722;
                5'd15: v = 32'sd20861;
                5'd16: v = 32'sd10430;
                5'd17: v = 32'sd5215;
                5'd18: v = 32'sd2608;
                5'd19: v = 32'sd1304;
                5'd20: v = 32'sd652;
                5'd21: v = 32'sd326;
                5'd22: v = 32'sd163;
                5'd23: v = 32'sd81;
                default: v = 32'sd0;
            endcase
            return v;
        end
    endfunction

    // clamp to [-1.0, 1.0] in q2.30
    function automatic logic signed [31:0] clamp_q30(input logic signed [39:0] v);
        logic signed [39:0] r;
        begin
            if (v > ONE_Q30) begin
                r = ONE_Q30;
            end else if (v < -ONE_Q30) begin
                r = -ONE_Q30;
            end else begin
                r = v;
            end
            return r[31:0];
        end
    endfunction

endpackage

/* rtl/core/pra_cordic.sv */
// ----------------------------------------------------------------------------
// pra_cordic
// rotation-mode cordic pipeline, one register stage per iteration
// ----------------------------------------------------------------------------
module pra_cordic #(
    parameter int STAGES = pra_pkg::CORDIC_STAGES_DEF
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] z_in,
    output logic signed [33:0] x_out,
    output logic signed [33:0] y_out
);

    logic signed [33:0] x_reg [STAGES];
    logic signed [33:0] y_reg [STAGES];
    logic signed [31:0] z_reg [STAGES];

    genvar i;
    generate
        for (i = 0; i < STAGES; i++) begin : g_stage
            logic signed [33:0] x_cur;
            logic signed [33:0] y_cur;
            logic signed [31:0] z_cur;
            logic signed [31:0] ang;

            // stage input: start value or previous stage
            if (i == 0) begin : g_first
                assign x_cur = pra_pkg::CORDIC_GAIN_Q30;
                assign y_cur = '0;
                assign z_cur = z_in;
            end else begin : g_next
                assign x_cur = x_reg[i-1];
                assign y_cur = y_reg[i-1];
                assign z_cur = z_reg[i-1];
            end

            assign ang = pra_pkg::atan_lookup(pra_pkg::ATAN_IDX_W'(i));

            // one micro-rotation, shifts round toward minus infinity
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (!z_cur[31]) begin
                        x_reg[i] <= x_cur - (y_cur >>> i);
                        y_reg[i] <= y_cur + (x_cur >>> i);
                        z_reg[i] <= z_cur - ang;
                    end else begin
                        x_reg[i] <= x_cur + (y_cur >>> i);
                        y_reg[i] <= y_cur - (x_cur >>> i);
                        z_reg[i] <= z_cur + ang;
                    end
                end
            end
        end
    endgenerate

    assign x_out = x_reg[STAGES-1];
    assign y_out = y_reg[STAGES-1];

endmodule

/* rtl/core/point_rotation_about_axis_unit.sv */
// ----------------------------------------------------------------------------
// point_rotation_about_axis_unit
// rotates a q16.16 point about a unit axis through a pivot (rodrigues)
// ----------------------------------------------------------------------------
// One item enters per cycle while no result waits unaccepted at the output,
// and each item gives one result item. The chain is the input register, one
// register per cordic iteration, then quadrant fold, matrix products, matrix
// entries, point products and the output register; all stages move together
// and hold while a result waits at the output, so a stall loses nothing.
module point_rotation_about_axis_unit #(
    parameter int CORDIC_STAGES = pra_pkg::CORDIC_STAGES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // point_x, point_y, point_z, pivot_x, pivot_y, pivot_z,
    // axis_x, axis_y, axis_z, turn_angle
    input  logic [pra_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // rotated_x, rotated_y, rotated_z, overflow_flag, zero fill
    output logic [pra_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic adv;

    // input stage
    logic               in_valid_reg;
    pra_pkg::side_t     in_side_reg;
    logic signed [31:0] in_z_reg;
    pra_pkg::side_t     in_side_next;
    logic signed [31:0] in_z_next;

    // cordic side line
    logic               cd_valid_reg [CORDIC_STAGES];
    pra_pkg::side_t     cd_side_reg  [CORDIC_STAGES];
    logic signed [33:0] cd_x;
    logic signed [33:0] cd_y;

    // quadrant stage
    logic               q_valid_reg;
    pra_pkg::side_t     q_side_reg;
    logic signed [31:0] q_c_reg, q_s_reg;
    logic signed [32:0] q_t_reg;
    logic signed [31:0] q_p_reg [6];
    logic signed [31:0] q_c_next, q_s_next;
    logic signed [32:0] q_t_next;
    logic signed [31:0] q_p_next [6];

    // matrix product stage
    logic               m_valid_reg;
    pra_pkg::side_t     m_side_reg;
    logic signed [31:0] m_pd_reg   [3];
    logic signed [64:0] m_diag_reg [3];
    logic signed [64:0] m_off_reg  [3];
    logic signed [47:0] m_as_reg   [3];
    logic signed [64:0] m_diag_next [3];
    logic signed [64:0] m_off_next  [3];
    logic signed [47:0] m_as_next   [3];

    // matrix entry stage
    logic               r_valid_reg;
    pra_pkg::side_t     r_side_reg;
    logic signed [31:0] r_e_reg  [9];
    logic signed [31:0] r_e_next [9];

    // point product stage
    logic               p_valid_reg;
    pra_pkg::side_t     p_side_reg;
    logic signed [65:0] p_prod_reg  [9];
    logic signed [65:0] p_prod_next [9];

    // output stage
    logic               out_valid_reg;
    logic signed [31:0] out_x_reg, out_y_reg, out_z_reg;
    logic               out_ovf_reg;
    logic signed [31:0] out_c_next [3];
    logic               out_ovf_next;

    // one shared stall for the whole chain
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // unpack, form the offset and reduce the angle
    always_comb begin
        logic [15:0]        u;
        logic signed [15:0] r16;
        u = s_tdata[255:240] + 16'h2000;
        r16 = $signed({2'b00, u[13:0]}) - 16'sd8192;
        in_side_next.pivot_x = s_tdata[127:96];
        in_side_next.pivot_y = s_tdata[159:128];
        in_side_next.pivot_z = s_tdata[191:160];
        in_side_next.dx = 34'($signed(s_tdata[31:0]))  - 34'($signed(s_tdata[127:96]));
        in_side_next.dy = 34'($signed(s_tdata[63:32])) - 34'($signed(s_tdata[159:128]));
        in_side_next.dz = 34'($signed(s_tdata[95:64])) - 34'($signed(s_tdata[191:160]));
        in_side_next.ax = s_tdata[207:192];
        in_side_next.ay = s_tdata[223:208];
        in_side_next.az = s_tdata[239:224];
        in_side_next.quad = u[15:14];
        in_z_next = {r16, 16'h0000};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_side_reg <= in_side_next;
            in_z_reg    <= in_z_next;
        end
    end

    pra_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .aclk  (aclk),
        .en    (adv),
        .z_in  (in_z_reg),
        .x_out (cd_x),
        .y_out (cd_y)
    );

    // side data runs beside the cordic
    genvar g;
    generate
        for (g = 0; g < CORDIC_STAGES; g++) begin : g_side
            if (g == 0) begin : g_first
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        cd_side_reg[g] <= in_side_reg;
                    end
                end
            end else begin : g_next
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        cd_side_reg[g] <= cd_side_reg[g-1];
                    end
                end
            end
        end
    endgenerate

    // quadrant fold, clamp, one minus cosine and axis products
    always_comb begin
        logic signed [39:0] cw, sw;
        pra_pkg::side_t     sd;
        sd = cd_side_reg[CORDIC_STAGES-1];
        unique case (sd.quad)
            pra_pkg::QUAD_0: begin
                cw = 40'(cd_x);  sw = 40'(cd_y);
            end
            pra_pkg::QUAD_1: begin
                cw = -40'(cd_y); sw = 40'(cd_x);
            end
            pra_pkg::QUAD_2: begin
                cw = -40'(cd_x); sw = -40'(cd_y);
            end
            pra_pkg::QUAD_3: begin
                cw = 40'(cd_y);  sw = -40'(cd_x);
            end
            default: begin
                cw = 40'(cd_x);  sw = 40'(cd_y);
            end
        endcase
        q_c_next = pra_pkg::clamp_q30(cw);
        q_s_next = pra_pkg::clamp_q30(sw);
        q_t_next = 33'sd1073741824 - 33'(q_c_next);
        q_p_next[0] = 32'(sd.ax) * 32'(sd.ax);
        q_p_next[1] = 32'(sd.ay) * 32'(sd.ay);
        q_p_next[2] = 32'(sd.az) * 32'(sd.az);
        q_p_next[3] = 32'(sd.ax) * 32'(sd.ay);
        q_p_next[4] = 32'(sd.ax) * 32'(sd.az);
        q_p_next[5] = 32'(sd.ay) * 32'(sd.az);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q_side_reg <= cd_side_reg[CORDIC_STAGES-1];
            q_c_reg    <= q_c_next;
            q_s_reg    <= q_s_next;
            q_t_reg    <= q_t_next;
            for (int k = 0; k < 6; k++) begin
                q_p_reg[k] <= q_p_next[k];
            end
        end
    end

    // matrix products
    always_comb begin
        logic signed [32:0] md;
        for (int k = 0; k < 3; k++) begin
            md = 33'sd268435456 - 33'(q_p_reg[k]);
            m_diag_next[k] = 65'(md) * 65'(q_c_reg);
            m_off_next[k]  = 65'(q_p_reg[k+3]) * 65'(q_t_reg);
        end
        m_as_next[0] = 48'(q_side_reg.ax) * 48'(q_s_reg);
        m_as_next[1] = 48'(q_side_reg.ay) * 48'(q_s_reg);
        m_as_next[2] = 48'(q_side_reg.az) * 48'(q_s_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_side_reg <= q_side_reg;
            for (int k = 0; k < 3; k++) begin
                m_pd_reg[k]   <= q_p_reg[k];
                m_diag_reg[k] <= m_diag_next[k];
                m_off_reg[k]  <= m_off_next[k];
                m_as_reg[k]   <= m_as_next[k];
            end
        end
    end

    // matrix entries, rounded and clamped, row-major
    always_comb begin
        logic signed [64:0] tmp;
        logic signed [47:0] tmp_s;
        logic signed [39:0] dg [3];
        logic signed [39:0] tt [3];
        logic signed [39:0] ss [3];
        for (int k = 0; k < 3; k++) begin
            tmp   = (m_diag_reg[k] + 65'sd134217728) >>> 28;
            dg[k] = (40'(m_pd_reg[k]) <<< 2) + tmp[39:0];
            tmp   = (m_off_reg[k] + 65'sd134217728) >>> 28;
            tt[k] = tmp[39:0];
            tmp_s = (m_as_reg[k] + 48'sd8192) >>> 14;
            ss[k] = 40'(tmp_s);
        end
        // tt: xy, xz, yz; ss: x, y, z
        r_e_next[0] = pra_pkg::clamp_q30(dg[0]);
        r_e_next[1] = pra_pkg::clamp_q30(tt[0] - ss[2]);
        r_e_next[2] = pra_pkg::clamp_q30(tt[1] + ss[1]);
        r_e_next[3] = pra_pkg::clamp_q30(tt[0] + ss[2]);
        r_e_next[4] = pra_pkg::clamp_q30(dg[1]);
        r_e_next[5] = pra_pkg::clamp_q30(tt[2] - ss[0]);
        r_e_next[6] = pra_pkg::clamp_q30(tt[1] - ss[1]);
        r_e_next[7] = pra_pkg::clamp_q30(tt[2] + ss[0]);
        r_e_next[8] = pra_pkg::clamp_q30(dg[2]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_side_reg <= m_side_reg;
            for (int k = 0; k < 9; k++) begin
                r_e_reg[k] <= r_e_next[k];
            end
        end
    end

    // matrix times offset
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            p_prod_next[3*k]   = 66'(r_e_reg[3*k])   * 66'(r_side_reg.dx);
            p_prod_next[3*k+1] = 66'(r_e_reg[3*k+1]) * 66'(r_side_reg.dy);
            p_prod_next[3*k+2] = 66'(r_e_reg[3*k+2]) * 66'(r_side_reg.dz);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_side_reg <= r_side_reg;
            for (int k = 0; k < 9; k++) begin
                p_prod_reg[k] <= p_prod_next[k];
            end
        end
    end

    // round, add the pivot back and saturate
    always_comb begin
        logic signed [65:0] tmp;
        logic signed [39:0] acc;
        logic signed [31:0] pv [3];
        pv[0] = p_side_reg.pivot_x;
        pv[1] = p_side_reg.pivot_y;
        pv[2] = p_side_reg.pivot_z;
        out_ovf_next = 1'b0;
        for (int k = 0; k < 3; k++) begin
            acc = 40'(pv[k]);
            for (int j = 0; j < 3; j++) begin
                tmp = (p_prod_reg[3*k+j] + 66'sd536870912) >>> 30;
                acc = acc + tmp[39:0];
            end
            if (acc > 40'sd2147483647) begin
                out_c_next[k] = 32'h7fffffff;
                out_ovf_next  = 1'b1;
            end else if (acc < -40'sd2147483648) begin
                out_c_next[k] = 32'h80000000;
                out_ovf_next  = 1'b1;
            end else begin
                out_c_next[k] = acc[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_x_reg   <= out_c_next[0];
            out_y_reg   <= out_c_next[1];
            out_z_reg   <= out_c_next[2];
            out_ovf_reg <= out_ovf_next;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            q_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            r_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < CORDIC_STAGES; k++) begin
                cd_valid_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            in_valid_reg    <= s_tvalid;
            cd_valid_reg[0] <= in_valid_reg;
            for (int k = 1; k < CORDIC_STAGES; k++) begin
                cd_valid_reg[k] <= cd_valid_reg[k-1];
            end
            q_valid_reg   <= cd_valid_reg[CORDIC_STAGES-1];
            m_valid_reg   <= q_valid_reg;
            r_valid_reg   <= m_valid_reg;
            p_valid_reg   <= r_valid_reg;
            out_valid_reg <= p_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_ovf_reg, out_z_reg, out_y_reg, out_x_reg};

endmodule

/* rtl/core/pra_checker.sv */
// ----------------------------------------------------------------------------
// pra_checker
// port-level checks of the axis-angle point rotation unit
// ----------------------------------------------------------------------------
module pra_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pra_pkg::M_TDATA_W-1:0] m_tdata
);

    // a held result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // a held result keeps its value
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result item changed while stalled");

    // input is taken whenever the output slot is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // overflow flag only with a saturated coordinate
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[96] |->
            (m_tdata[31:0] == 32'h7fffffff || m_tdata[31:0] == 32'h80000000 ||
             m_tdata[63:32] == 32'h7fffffff || m_tdata[63:32] == 32'h80000000 ||
             m_tdata[95:64] == 32'h7fffffff || m_tdata[95:64] == 32'h80000000))
        else $error("overflow flag without saturated coordinate");

    // zero fill above the flag
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[103:97] == 7'b0)
        else $error("fill bits of result item not zero");

endmodule

bind point_rotation_about_axis_unit pra_checker u_pra_checker (.*);
